/* sv/ghp_pkg.sv */
// ----------------------------------------------------------------------------
// ghp_pkg: shared types and constants of the generational handle pool
// Pool size, derived widths, command and status codes, port words and the
// control words that pass between the pool's modules.
// ----------------------------------------------------------------------------
package ghp_pkg;

    localparam int SLOTS     = 256;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int SLOT_ID_W = 8;
    localparam int GEN_W     = 32;
    // compare width wide enough for both a slot id and the pool count
    localparam int CMP_W     = (CNT_W > SLOT_ID_W) ? CNT_W : SLOT_ID_W + 1;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        GSEL_ONE = 2'd0,
        GSEL_MEM = 2'd1,
        GSEL_INC = 2'd2
    } gsel_t;

    typedef struct packed {
        func_t                  func;
        logic [SLOT_ID_W-1:0]   slot_id;
    } req_t;

    typedef struct packed {
        logic [SLOT_ID_W-1:0]   result_slot;
        logic [GEN_W-1:0]       generation;
        logic                   alive;
        status_t                status;
    } rsp_t;

    typedef struct packed {
        logic                   push;
        logic                   pop;
        logic                   clear;
        logic [IDX_W-1:0]       push_id;
    } stack_cmd_t;

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
        logic [GEN_W-1:0]       data;
    } gen_wr_t;

endpackage

/* sv/ghp_free_stack.sv */
// ----------------------------------------------------------------------------
// ghp_free_stack: LIFO of freed slot numbers
// Entries live in a memory; the top two are cached in registers so that a
// pop can follow a pop in the next cycle.
// ----------------------------------------------------------------------------
module ghp_free_stack (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ghp_pkg::stack_cmd_t         cmd,
    output logic [ghp_pkg::IDX_W-1:0]   top,
    output logic [ghp_pkg::CNT_W-1:0]   count
);
    import ghp_pkg::*;

    logic [IDX_W-1:0] stack_mem [SLOTS];
    logic [IDX_W-1:0] top_reg;
    logic [IDX_W-1:0] second_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] third_pos;

    // position of the entry that becomes second after a pop
    assign third_pos = count_reg - CNT_W'(3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
        end
        else if (cmd.push)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // write the pushed id at its own position, shift the cached pair
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[count_reg[IDX_W-1:0]] <= cmd.push_id;
            top_reg                         <= cmd.push_id;
            second_reg                      <= top_reg;
        end
        else if (cmd.pop)
        begin
            top_reg    <= second_reg;
            second_reg <= stack_mem[third_pos[IDX_W-1:0]];
        end
    end

    assign top   = top_reg;
    assign count = count_reg;

endmodule

/* sv/ghp_gen_store.sv */
// ----------------------------------------------------------------------------
// ghp_gen_store: per-slot generation memory
// One write and one registered read per cycle; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module ghp_gen_store (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ghp_pkg::IDX_W-1:0]   rd_addr,
    input  ghp_pkg::gen_wr_t            wr,
    output logic [ghp_pkg::GEN_W-1:0]   rd_data
);
    import ghp_pkg::*;

    logic [GEN_W-1:0] gen_mem [SLOTS];
    logic [GEN_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            gen_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            // bypass the write of the op ahead
            rd_data_reg <= (wr.en && (wr.addr == rd_addr)) ? wr.data : gen_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/generational_handle_pool.sv */
// ----------------------------------------------------------------------------
// generational_handle_pool: generational slot allocator
// Hands out slot handles with 32-bit generations, recycles freed slots LIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req (func, slot_id) and pulse start; the word is taken at any edge
//   where start is high and busy is low. busy stays low, so a command may be
//   issued in every cycle: one word per cycle sustained.
//   Each command yields exactly one response word on rsp, marked by done for
//   one cycle, once the command has passed the stage 1 registers and the
//   response register. Responses come in command order.
//   The receiver cannot stall: it must take rsp in the cycle done is high.
//   Latency is set by the registered read of the generation memory followed
//   by the response register; the free stack caches its top two entries so
//   back-to-back allocates pop without waiting on its memory.
//   Reset: the pool holds only the null slot, the free stack is empty and
//   all alive marks are clear. No clearing pass runs; a clear command has
//   the same effect at once and may be followed by a command next cycle.
// ----------------------------------------------------------------------------
module generational_handle_pool (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ghp_pkg::req_t   req,
    output logic            done,
    output ghp_pkg::rsp_t   rsp
);
    import ghp_pkg::*;

    // pool state
    logic [CNT_W-1:0]       used_reg;
    logic [SLOTS-1:0]       alive_reg;

    // free stack and generation memory hookup
    stack_cmd_t             stack_cmd;
    logic [IDX_W-1:0]       stack_top;
    logic [CNT_W-1:0]       stack_count;
    gen_wr_t                gen_wr;
    logic [GEN_W-1:0]       gen_rd;

    // decode of the incoming command
    logic                   accept;
    logic                   in_pool;
    logic [IDX_W-1:0]       id_idx;
    logic                   id_alive;
    logic                   have_free;
    logic                   pool_room;
    logic                   stack_room;

    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       waddr_next;
    logic [SLOT_ID_W-1:0]   rslot_next;
    gsel_t                  gsel_next;
    logic                   alive_next;
    status_t                status_next;
    logic                   wr_next;
    logic                   set_alive;
    logic                   clr_alive;
    logic                   grow;
    logic                   do_clear;
    logic                   do_push;
    logic                   do_pop;

    // stage 1: waiting on the generation read
    logic                   s1_valid_reg;
    logic                   s1_wr_reg;
    logic [IDX_W-1:0]       s1_waddr_reg;
    logic [SLOT_ID_W-1:0]   s1_rslot_reg;
    gsel_t                  s1_gsel_reg;
    logic                   s1_alive_reg;
    status_t                s1_status_reg;
    logic [GEN_W-1:0]       gen_out;

    // response register
    logic                   done_reg;
    rsp_t                   rsp_reg;

    // every command finishes in a fixed pipeline, never hold off
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign id_idx     = IDX_W'(req.slot_id);
    assign id_alive   = alive_reg[id_idx];
    assign in_pool    = (req.slot_id != '0) && (CMP_W'(req.slot_id) < CMP_W'(used_reg));
    assign have_free  = (stack_count != '0);
    assign pool_room  = (used_reg < CNT_W'(SLOTS));
    assign stack_room = (stack_count < CNT_W'(SLOTS));

    // resolve the command against the current pool state
    always_comb
    begin
        rd_addr     = id_idx;
        waddr_next  = id_idx;
        rslot_next  = req.slot_id;
        gsel_next   = GSEL_ONE;
        alive_next  = 1'b0;
        status_next = ST_BAD;
        wr_next     = 1'b0;
        set_alive   = 1'b0;
        clr_alive   = 1'b0;
        grow        = 1'b0;
        do_clear    = 1'b0;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        unique case (req.func)
            FUNC_ALLOC:
            begin
                if (have_free)
                begin
                    // reuse the most recently freed slot, bump its generation
                    rd_addr     = stack_top;
                    waddr_next  = stack_top;
                    rslot_next  = SLOT_ID_W'(stack_top);
                    gsel_next   = GSEL_INC;
                    alive_next  = 1'b1;
                    status_next = ST_OK;
                    wr_next     = 1'b1;
                    set_alive   = 1'b1;
                    do_pop      = 1'b1;
                end
                else if (pool_room)
                begin
                    // open a fresh slot at generation one
                    waddr_next  = IDX_W'(used_reg);
                    rslot_next  = SLOT_ID_W'(used_reg);
                    gsel_next   = GSEL_ONE;
                    alive_next  = 1'b1;
                    status_next = ST_OK;
                    wr_next     = 1'b1;
                    set_alive   = 1'b1;
                    grow        = 1'b1;
                end
                else
                begin
                    rslot_next  = '0;
                    status_next = ST_FULL;
                end
            end
            FUNC_FREE:
            begin
                if (in_pool && id_alive && stack_room)
                begin
                    gsel_next   = GSEL_MEM;
                    status_next = ST_OK;
                    clr_alive   = 1'b1;
                    do_push     = 1'b1;
                end
                else if (in_pool)
                begin
                    // refuse a double free, report the slot as it stands
                    gsel_next   = GSEL_MEM;
                    alive_next  = id_alive;
                end
            end
            FUNC_QUERY:
            begin
                if (in_pool)
                begin
                    gsel_next   = GSEL_MEM;
                    alive_next  = id_alive;
                    status_next = id_alive ? ST_OK : ST_BAD;
                end
            end
            FUNC_CLEAR:
            begin
                rslot_next  = '0;
                status_next = ST_OK;
                do_clear    = 1'b1;
            end
        endcase
    end

    assign stack_cmd.push    = accept & do_push;
    assign stack_cmd.pop     = accept & do_pop;
    assign stack_cmd.clear   = accept & do_clear;
    assign stack_cmd.push_id = id_idx;

    ghp_free_stack u_free_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stack_cmd),
        .top   (stack_top),
        .count (stack_count)
    );

    ghp_gen_store u_gen_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (gen_wr),
        .rd_data (gen_rd)
    );

    // pool count and alive marks update at the accepting edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= CNT_W'(1);
            alive_reg <= '0;
        end
        else if (accept)
        begin
            if (do_clear)
            begin
                used_reg  <= CNT_W'(1);
                alive_reg <= '0;
            end
            else
            begin
                if (grow)
                begin
                    used_reg <= used_reg + CNT_W'(1);
                end
                if (set_alive)
                begin
                    alive_reg[waddr_next] <= 1'b1;
                end
                if (clr_alive)
                begin
                    alive_reg[id_idx] <= 1'b0;
                end
            end
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_wr_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_wr_reg    <= accept & wr_next;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_waddr_reg  <= waddr_next;
            s1_rslot_reg  <= rslot_next;
            s1_gsel_reg   <= gsel_next;
            s1_alive_reg  <= alive_next;
            s1_status_reg <= status_next;
        end
    end

    // pick the reported generation; it is also what gets written back
    always_comb
    begin
        case (s1_gsel_reg)
            GSEL_MEM: gen_out = gen_rd;
            GSEL_INC: gen_out = gen_rd + GEN_W'(1);
            default:  gen_out = GEN_W'(1);
        endcase
    end

    assign gen_wr.en   = s1_valid_reg & s1_wr_reg;
    assign gen_wr.addr = s1_waddr_reg;
    assign gen_wr.data = gen_out;

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            rsp_reg.result_slot <= s1_rslot_reg;
            rsp_reg.generation  <= gen_out;
            rsp_reg.alive       <= s1_alive_reg;
            rsp_reg.status      <= s1_status_reg;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for generational_handle_pool
// Commands go in through the start/busy handshake and are mirrored in a
// scoreboard that keeps its own copy of the pool. Each response word is
// checked field by field against the oldest predicted word. A directed opening
// is followed by a long random run that fills the pool, recycles slots and
// clears it.
// ----------------------------------------------------------------------------
module tb;
    import ghp_pkg::*;

    // Mirror of the pool. It predicts one response word per command and
    // queues the words until the block hands its own out.
    class pool_scoreboard;
        logic [GEN_W-1:0]   gen_tab [SLOTS];
        bit                 live_tab [SLOTS];
        int unsigned        pool_used;
        logic [IDX_W-1:0]   stack_mem [SLOTS];
        int unsigned        stack_depth;
        rsp_t               expected_q [$];
        int unsigned        errors;

        function new();
            wipe();
            errors = 0;
        endfunction

        // Drop everything but the null slot.
        function void wipe();
            for (int i = 0; i < SLOTS; i++)
            begin
                gen_tab[i]   = '0;
                live_tab[i]  = 1'b0;
                stack_mem[i] = '0;
            end
            gen_tab[0]  = 1;
            pool_used   = 1;
            stack_depth = 0;
        endfunction

        function bit in_pool(int unsigned id);
            return id > 0 && id < pool_used && id < SLOTS;
        endfunction

        function bit is_full();
            return stack_depth == 0 && pool_used == SLOTS;
        endfunction

        // First live slot at or above the given one, wrapping; 0 if none.
        function int unsigned find_live(int unsigned from);
            int unsigned id;
            for (int k = 0; k < SLOTS; k++)
            begin
                id = (from + k) % SLOTS;
                if (in_pool(id) && live_tab[id])
                    return id;
            end
            return 0;
        endfunction

        function void note_word(req_t w);
            rsp_t        e;
            int unsigned id;
            int unsigned idx;
            id            = w.slot_id;
            e.result_slot = w.slot_id;
            e.generation  = 1;
            e.alive       = 1'b0;
            e.status      = ST_BAD;
            case (w.func)
                FUNC_ALLOC:
                begin
                    if (stack_depth > 0)
                    begin
                        stack_depth--;
                        idx           = stack_mem[stack_depth];
                        gen_tab[idx]  = gen_tab[idx] + 1'b1;
                        live_tab[idx] = 1'b1;
                        e.result_slot = SLOT_ID_W'(idx);
                        e.generation  = gen_tab[idx];
                        e.alive       = 1'b1;
                        e.status      = ST_OK;
                    end
                    else if (pool_used < SLOTS)
                    begin
                        idx           = pool_used;
                        gen_tab[idx]  = 1;
                        live_tab[idx] = 1'b1;
                        pool_used++;
                        e.result_slot = SLOT_ID_W'(idx);
                        e.generation  = 1;
                        e.alive       = 1'b1;
                        e.status      = ST_OK;
                    end
                    else
                    begin
                        e.result_slot = '0;
                        e.status      = ST_FULL;
                    end
                end
                FUNC_FREE:
                begin
                    if (in_pool(id) && live_tab[id] && stack_depth < SLOTS)
                    begin
                        live_tab[id]           = 1'b0;
                        stack_mem[stack_depth] = IDX_W'(id);
                        stack_depth++;
                        e.generation = gen_tab[id];
                        e.status     = ST_OK;
                    end
                    else if (in_pool(id))
                    begin
                        e.generation = gen_tab[id];
                        e.alive      = live_tab[id];
                    end
                end
                FUNC_QUERY:
                begin
                    if (in_pool(id))
                    begin
                        e.generation = gen_tab[id];
                        e.alive      = live_tab[id];
                        e.status     = live_tab[id] ? ST_OK : ST_BAD;
                    end
                end
                default:
                begin
                    wipe();
                    e.result_slot = '0;
                    e.status      = ST_OK;
                end
            endcase
            expected_q.insert(expected_q.size(), e);
        endfunction

        function void check_word(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response word: slot %0h generation %0h",
                       got.result_slot, got.generation);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.result_slot !== e.result_slot)
            begin
                $error("result_slot expected %0h actual %0h", e.result_slot, got.result_slot);
                errors++;
            end
            if (got.generation !== e.generation)
            begin
                $error("generation expected %0h actual %0h", e.generation, got.generation);
                errors++;
            end
            if (got.alive !== e.alive)
            begin
                $error("alive expected %0h actual %0h", e.alive, got.alive);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status expected %0h actual %0h", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_TAIL    = 200;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    req_t   req;
    logic   done;
    rsp_t   rsp;

    pool_scoreboard sb = new();

    generational_handle_pool DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watch both sides at every edge. Check the outgoing word first: it
    // belongs to a command taken at an earlier edge, never to the one taken now.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_word(rsp);
            if (start && !busy)
                sb.note_word(req);
        end
    end

    // Present one command word and hold it until an edge takes it.
    task automatic issue(input func_t f, input logic [SLOT_ID_W-1:0] id);
        start <= 1'b1;
        req   <= '{func: f, slot_id: id};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start for as many cycles as the caller asks.
    task automatic hold_off(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Aim a free or query: mostly at a live slot, else anywhere in or just
    // past the pool, else at any id at all.
    function automatic logic [SLOT_ID_W-1:0] aim_slot();
        int unsigned r;
        int unsigned id;
        r = $urandom_range(99);
        if (r < 60)
        begin
            id = sb.find_live($urandom_range(SLOTS - 1));
            if (id != 0)
                return SLOT_ID_W'(id);
        end
        if (r < 85)
            return SLOT_ID_W'($urandom_range(0, sb.pool_used));
        return SLOT_ID_W'($urandom);
    endfunction

    function automatic req_t pick_word();
        req_t        w;
        int unsigned r;
        w.slot_id = SLOT_ID_W'($urandom);
        r = $urandom_range(99);
        if (r < 37)
            w.func = FUNC_ALLOC;
        else if (r < 67)
        begin
            w.func    = FUNC_FREE;
            w.slot_id = aim_slot();
        end
        else if (r < 99)
        begin
            w.func    = FUNC_QUERY;
            w.slot_id = aim_slot();
        end
        else
            w.func = FUNC_CLEAR;
        return w;
    endfunction

    initial
    begin
        req_t        w;
        bit          filling;
        bit          gappy;
        int unsigned spill;
        int unsigned fill_at;

        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: null and out-of-range ids on an empty pool.
        issue(FUNC_QUERY, 8'h00);
        issue(FUNC_QUERY, 8'hFF);
        issue(FUNC_FREE,  8'h00);
        issue(FUNC_FREE,  8'hFF);
        // Grow by fresh slots; the slot_id of an allocate is ignored.
        issue(FUNC_ALLOC, 8'hFF);
        issue(FUNC_ALLOC, 8'h00);
        issue(FUNC_ALLOC, 8'hAA);
        issue(FUNC_QUERY, 8'h02);
        // Free, then refuse a second free of the now dead slot.
        issue(FUNC_FREE,  8'h02);
        issue(FUNC_FREE,  8'h02);
        issue(FUNC_QUERY, 8'h02);
        // Reuse bumps the generation.
        issue(FUNC_ALLOC, 8'h55);
        issue(FUNC_QUERY, 8'h02);
        // Recycling is last in, first out.
        issue(FUNC_FREE,  8'h01);
        issue(FUNC_FREE,  8'h03);
        issue(FUNC_ALLOC, 8'h00);
        issue(FUNC_ALLOC, 8'h00);
        issue(FUNC_QUERY, 8'h04);
        // Clear with every slot_id bit set, then see the old slots gone.
        issue(FUNC_CLEAR, 8'hFF);
        issue(FUNC_QUERY, 8'h01);
        issue(FUNC_FREE,  8'h01);
        issue(FUNC_ALLOC, 8'h00);
        issue(FUNC_CLEAR, 8'h00);

        // Random run. Once early on, and now and then after, allocate until
        // the pool is full and a few more past that point.
        filling = 1'b0;
        gappy   = 1'b0;
        spill   = 0;
        fill_at = $urandom_range(200, 900);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                gappy = 1'($urandom_range(1));
            if (n >= RANDOM_ITEMS - CALM_TAIL)
                gappy = 1'b0;
            if (!filling && (n == fill_at || $urandom_range(599) == 0))
            begin
                filling = 1'b1;
                spill   = $urandom_range(2, 5);
            end
            if (filling)
            begin
                issue(FUNC_ALLOC, SLOT_ID_W'($urandom));
                if (sb.is_full())
                begin
                    if (spill == 0)
                        filling = 1'b0;
                    else
                        spill--;
                end
            end
            else
            begin
                w = pick_word();
                issue(w.func, w.slot_id);
            end
            if (gappy && $urandom_range(3) == 0)
                hold_off($urandom_range(1, 7));
        end

        // Drain: let the last words come out, then a margin past the latency.
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS generational_handle_pool");
        else
            $display("FAIL generational_handle_pool");
        $finish;
    end

    // Watchdog: a correct run ends far sooner.
    initial
    begin
        #5_000_000;
        $display("FAIL generational_handle_pool");
        $finish;
    end

endmodule
